/* rtl/core/sliding_window_median_core_macros.svh */
// Assertion macros used by sliding_window_median_core.
`ifndef SLIDING_WINDOW_MEDIAN_CORE_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_CORE_MACROS_SVH

// Checked at every rising edge of clk, and not while rst is high.
`define SWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge of clk, during reset too.
`define SWM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/swm_pkg.sv */
package swm_pkg;

  localparam int SWM_MAX_WINDOW   = 64;
  localparam int SWM_SAMPLE_WIDTH = 32;
  localparam int SWM_CFG_WIDTH    = 7;
  localparam int SWM_WIN_RESET    = 3;
  localparam int SWM_TAP_GROUP    = 8;

  typedef struct packed {
    logic load;
    logic evict_en;
    logic clear;
  } swm_ctl_t;

  typedef struct packed {
    logic valid;
    logic ge_x;
    logic gt_v;
  } swm_flags_t;

endpackage

/* rtl/core/swm_cell.sv */
module swm_cell import swm_pkg::*; #(
  parameter int SAMPLE_WIDTH = SWM_SAMPLE_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  swm_ctl_t                ctl,
  input  logic [SAMPLE_WIDTH-1:0] new_value,
  input  logic [SAMPLE_WIDTH-1:0] evict_value,
  input  logic [SAMPLE_WIDTH-1:0] left_value,
  input  swm_flags_t              left_flags,
  input  logic [SAMPLE_WIDTH-1:0] right_value,
  input  swm_flags_t              right_flags,
  output logic [SAMPLE_WIDTH-1:0] value,
  output swm_flags_t              flags
);

  logic                    valid;
  logic                    own_ev;
  logic                    left_ev;
  logic [SAMPLE_WIDTH-1:0] rem_val;
  logic                    rem_vld;
  logic                    rem_gt;
  logic [SAMPLE_WIDTH-1:0] reml_val;
  logic                    reml_vld;
  logic                    reml_gt;
  logic [SAMPLE_WIDTH-1:0] value_next;
  logic                    valid_next;

  // An empty cell compares as larger than any sample.
  assign flags.valid = valid;
  assign flags.ge_x  = !valid || ($signed(value) >= $signed(evict_value));
  assign flags.gt_v  = !valid || ($signed(value) > $signed(new_value));

  assign own_ev  = ctl.evict_en && flags.ge_x;
  assign left_ev = ctl.evict_en && left_flags.ge_x;

  // The row after removal of the evicted entry, at this place and one to the left.
  always_comb begin
    rem_val  = own_ev ? right_value       : value;
    rem_vld  = own_ev ? right_flags.valid : valid;
    rem_gt   = own_ev ? right_flags.gt_v  : flags.gt_v;
    reml_val = left_ev ? value       : left_value;
    reml_vld = left_ev ? valid       : left_flags.valid;
    reml_gt  = left_ev ? flags.gt_v  : left_flags.gt_v;
  end

  always_comb begin
    if (rem_gt) begin
      if (reml_gt) begin
        value_next = reml_val;
        valid_next = reml_vld;
      end else begin
        value_next = new_value;
        valid_next = 1'b1;
      end
    end else begin
      value_next = rem_val;
      valid_next = rem_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      valid <= 1'b0;
    end else if (ctl.load) begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      value <= value_next;
    end
  end

endmodule

/* rtl/core/swm_tap.sv */
module swm_tap import swm_pkg::*; #(
  parameter int MAX_WINDOW   = SWM_MAX_WINDOW,
  parameter int SAMPLE_WIDTH = SWM_SAMPLE_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 capture,
  input  logic [MAX_WINDOW-1:0][SAMPLE_WIDTH-1:0] cells,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]      mid,
  output logic [SAMPLE_WIDTH-1:0]              tap_value
);

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int LO_W  = $clog2(SWM_TAP_GROUP);
  localparam int NG    = (MAX_WINDOW + SWM_TAP_GROUP - 1) / SWM_TAP_GROUP;

  logic [CNT_W+LO_W-1:0]   mid_x;
  logic [LO_W-1:0]         mid_lo;
  logic [CNT_W-1:0]        mid_hi;
  logic [SAMPLE_WIDTH-1:0] cand [NG][SWM_TAP_GROUP];
  logic [SAMPLE_WIDTH-1:0] grp_next [NG];
  logic [SAMPLE_WIDTH-1:0] grp [NG];

  assign mid_x  = {{LO_W{1'b0}}, mid};
  assign mid_lo = mid_x[LO_W-1:0];
  assign mid_hi = mid_x[CNT_W+LO_W-1:LO_W];

  for (genvar g = 0; g < NG; g++) begin : g_grp
    for (genvar k = 0; k < SWM_TAP_GROUP; k++) begin : g_k
      if (g * SWM_TAP_GROUP + k < MAX_WINDOW) begin : g_on
        assign cand[g][k] = cells[g * SWM_TAP_GROUP + k];
      end else begin : g_off
        assign cand[g][k] = '0;
      end
    end
  end

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_next[g] = '0;
      for (int k = 0; k < SWM_TAP_GROUP; k++) begin
        if (mid_lo == LO_W'(k)) begin
          grp_next[g] = cand[g][k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      grp <= grp_next;
    end
  end

  always_comb begin
    tap_value = '0;
    for (int g = 0; g < NG; g++) begin
      if (mid_hi == CNT_W'(g)) begin
        tap_value = grp[g];
      end
    end
  end

endmodule

/* rtl/core/sliding_window_median_core.sv */
// An item that completes a window gives its median after acceptance through the cell update,
// tap group select and output load; the input is held off until the output load is done.
// While the window fills, one sample is taken every cycle while no median is pending, and gives no transaction.
// Reset (rst, synchronous) sets the window size (win) to 3 and empties the window; the sample ring
// is not cleared, since only entries written since the last configuration are read.
`include "sliding_window_median_core_macros.svh"

module sliding_window_median_core import swm_pkg::*; #(
  parameter int MAX_WINDOW   = SWM_MAX_WINDOW,
  parameter int SAMPLE_WIDTH = SWM_SAMPLE_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [SWM_CFG_WIDTH-1:0]            cfg_wdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // Fields from bit 0: sample.
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // Fields from bit 0: median.
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   m_axis_tdata
);

  localparam int TD_W    = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
  localparam int IDX_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WIN_RST = (SWM_WIN_RESET > MAX_WINDOW) ? MAX_WINDOW : SWM_WIN_RESET;

  logic [CNT_W-1:0]        win;
  logic [CNT_W-1:0]        win_next;
  logic [CNT_W-1:0]        mid;
  logic [CNT_W:0]          mid_sum;
  logic [CNT_W-1:0]        fill;
  logic [IDX_W-1:0]        wp;
  logic [CNT_W-1:0]        wp_inc;
  logic [IDX_W-1:0]        wp_next;
  logic [IDX_W-1:0]        rd_addr;
  logic [SAMPLE_WIDTH-1:0] ring [MAX_WINDOW];
  logic [SAMPLE_WIDTH-1:0] evict_value;
  logic [SAMPLE_WIDTH-1:0] sample;
  logic                    accept;
  logic                    full;
  logic                    has_result;
  logic                    p1;
  logic                    p2;
  logic                    out_load;
  logic [SAMPLE_WIDTH-1:0] median;
  logic [SAMPLE_WIDTH-1:0] tap_value;
  swm_ctl_t                ctl;

  logic [MAX_WINDOW-1:0][SAMPLE_WIDTH-1:0] cell_value;
  swm_flags_t                              cell_flags [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]                   cell_valid;

  assign sample        = s_axis_tdata[SAMPLE_WIDTH-1:0];
  assign s_axis_tready = !p1 && !p2;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = (fill == win);
  assign has_result    = full || (({1'b0, fill} + 1'b1) == {1'b0, win});

  always_comb begin
    if (cfg_wdata == '0) begin
      win_next = CNT_W'(1);
    end else if (32'(cfg_wdata) > MAX_WINDOW) begin
      win_next = CNT_W'(MAX_WINDOW);
    end else begin
      win_next = CNT_W'(cfg_wdata);
    end
    mid_sum = ({1'b0, win_next} + 1'b1) >> 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= CNT_W'(WIN_RST);
      mid <= CNT_W'((WIN_RST + 1) / 2 - 1);
    end else if (cfg_we) begin
      win <= win_next;
      mid <= CNT_W'(mid_sum - 1'b1);
    end
  end

  assign wp_inc  = CNT_W'(wp) + 1'b1;
  assign wp_next = (wp_inc == win) ? '0 : IDX_W'(wp_inc);
  assign rd_addr = cfg_we ? '0 : (accept ? wp_next : wp);

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      fill <= '0;
      wp   <= '0;
    end else if (accept) begin
      wp <= wp_next;
      if (!full) begin
        fill <= fill + 1'b1;
      end
    end
  end

  // The ring slot of the next sample is read ahead, so the evicted value is ready.
  always_ff @(posedge clk) begin
    if (accept) begin
      ring[wp] <= sample;
    end
    if (accept && !cfg_we && (wp_next == wp)) begin
      evict_value <= sample;
    end else begin
      evict_value <= ring[rd_addr];
    end
  end

  assign ctl.load     = accept;
  assign ctl.evict_en = full;
  assign ctl.clear    = cfg_we;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic [SAMPLE_WIDTH-1:0] lv;
    logic [SAMPLE_WIDTH-1:0] rv;
    swm_flags_t              lf;
    swm_flags_t              rf;

    if (i == 0) begin : g_first
      assign lv = '0;
      assign lf = '{valid: 1'b0, ge_x: 1'b0, gt_v: 1'b0};
    end else begin : g_mid_l
      assign lv = cell_value[i-1];
      assign lf = cell_flags[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_last
      assign rv = '0;
      assign rf = '{valid: 1'b0, ge_x: 1'b1, gt_v: 1'b1};
    end else begin : g_mid_r
      assign rv = cell_value[i+1];
      assign rf = cell_flags[i+1];
    end

    swm_cell #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .new_value  (sample),
      .evict_value(evict_value),
      .left_value (lv),
      .left_flags (lf),
      .right_value(rv),
      .right_flags(rf),
      .value      (cell_value[i]),
      .flags      (cell_flags[i])
    );

    assign cell_valid[i] = cell_flags[i].valid;
  end

  swm_tap #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_tap (
    .clk      (clk),
    .capture  (p1),
    .cells    (cell_value),
    .mid      (mid),
    .tap_value(tap_value)
  );

  assign out_load = p2 && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1            <= 1'b0;
      p2            <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      p1 <= accept && has_result;
      if (p1) begin
        p2 <= 1'b1;
      end else if (out_load) begin
        p2 <= 1'b0;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      median <= tap_value;
    end
  end

  assign m_axis_tdata = TD_W'(median);

  `SWM_ASSERT(a_fill_matches_cells, ($countones(cell_valid) == fill), "cell count differs from fill")
  `SWM_ASSERT(a_wp_in_window, (CNT_W'(wp) < win), "write pointer outside window")
  `SWM_ASSERT(a_result_flow, (accept && has_result) |=> (p1 ##1 p2), "result did not advance")
  `SWM_ASSERT_ALWAYS(a_stall_holds, (!rst && p2 && m_axis_tvalid && !m_axis_tready) |=> p2, "pending median lost")

endmodule

/* verif/tb_sliding_window_median_core.sv */
module tb_sliding_window_median_core import swm_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [SWM_SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [SWM_CFG_WIDTH-1:0] win_cfg_t;

  localparam int      DATA_W       = ((SWM_SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int      TARGET_ITEMS = 1800;
  localparam int      DRAIN_CYCLES = 8;
  localparam int      STALL_LIMIT  = 1000;
  localparam int      REPORT_LIMIT = 10;
  localparam sample_t SAMPLE_MIN   = {1'b1, {(SWM_SAMPLE_WIDTH-1){1'b0}}};
  localparam sample_t SAMPLE_MAX   = {1'b0, {(SWM_SAMPLE_WIDTH-1){1'b1}}};

  class median_scoreboard;
    sample_t window_samples[$];
    sample_t expected_medians[$];
    int      window_len;
    int      mismatches;

    function new();
      window_len = SWM_WIN_RESET;
      mismatches = 0;
    endfunction

    function void set_window(win_cfg_t value);
      if (value == 0) begin
        window_len = 1;
      end else if (value > SWM_MAX_WINDOW) begin
        window_len = SWM_MAX_WINDOW;
      end else begin
        window_len = int'(value);
      end
      window_samples.delete();
    endfunction

    function sample_t lower_median();
      sample_t ordered[$];
      sample_t held;
      int      j;
      ordered = window_samples;
      for (int i = 1; i < ordered.size(); i++) begin
        held = ordered[i];
        j = i;
        while (j > 0 && ordered[j-1] > held) begin
          ordered[j] = ordered[j-1];
          j--;
        end
        ordered[j] = held;
      end
      return ordered[(window_len + 1) / 2 - 1];
    endfunction

    function void note_sample(sample_t value);
      window_samples.push_back(value);
      if (window_samples.size() > window_len) begin
        void'(window_samples.pop_front());
      end
      if (window_samples.size() == window_len) begin
        expected_medians.push_back(lower_median());
      end
    endfunction

    function void check_median(sample_t actual);
      sample_t want;
      if (expected_medians.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("unexpected median transaction: median=%0d", actual);
        end
        return;
      end
      want = expected_medians.pop_front();
      if (actual !== want) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("median mismatch: expected %0d, actual %0d", want, actual);
        end
      end
    endfunction

    function int pending();
      return expected_medians.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  win_cfg_t          cfg_wdata;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [DATA_W-1:0] m_axis_tdata;

  median_scoreboard sb;
  bit               tx_steady;
  bit               rx_steady;

  always #2 clk = ~clk;

  sliding_window_median_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  function automatic sample_t random_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return sample_t'($urandom);
      4, 5, 6: return sample_t'(int'($urandom_range(0, 8)) - 4);
      7: begin
        case ($urandom_range(0, 3))
          0: return SAMPLE_MIN;
          1: return SAMPLE_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return sample_t'(int'($urandom_range(0, 200)) - 100);
    endcase
  endfunction

  task automatic send_sample(input sample_t value);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= DATA_W'(value);
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // The window can only be changed with no sample in flight.
  task automatic write_window(input win_cfg_t value);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_window(value);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_sample(sample_t'(s_axis_tdata[SWM_SAMPLE_WIDTH-1:0]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_median(sample_t'(m_axis_tdata[SWM_SAMPLE_WIDTH-1:0]));
      end
    end
  end

  initial begin
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = rx_steady ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("tb_sliding_window_median_core failed");
    $finish;
  end

  initial begin
    int       sent;
    int       phase;
    int       count;
    win_cfg_t wsize;
    sb = new();
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset window of three: extremes, repeated values and the eviction of one copy.
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample('0);
    send_sample('1);
    send_sample('1);
    send_sample(sample_t'(1));
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample('0);
    write_window(win_cfg_t'(1));
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(sample_t'(5));
    // A window size of zero behaves as a window of one.
    write_window('0);
    send_sample(sample_t'(-7));
    send_sample(sample_t'(7));
    // An even window takes the lower of the two middle values.
    write_window(win_cfg_t'(4));
    send_sample(sample_t'(3));
    send_sample(sample_t'(3));
    send_sample(sample_t'(3));
    send_sample(sample_t'(-2));
    send_sample(sample_t'(3));
    send_sample(SAMPLE_MIN);
    send_sample(sample_t'(3));

    sent  = 0;
    phase = 0;
    while (sent < TARGET_ITEMS) begin
      case (phase)
        0: wsize = win_cfg_t'(SWM_MAX_WINDOW);
        1: wsize = '1;
        2: wsize = win_cfg_t'(2);
        3: wsize = '0;
        default: begin
          if ($urandom_range(0, 7) == 0) begin
            wsize = win_cfg_t'($urandom_range(0, 127));
          end else begin
            wsize = win_cfg_t'($urandom_range(1, 9));
          end
        end
      endcase
      write_window(wsize);
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      count = $urandom_range(30, 120) +
              ((wsize > SWM_MAX_WINDOW) ? SWM_MAX_WINDOW : int'(wsize));
      repeat (count) send_sample(random_sample());
      sent += count;
      phase++;
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_sliding_window_median_core passed");
    end else begin
      $display("tb_sliding_window_median_core failed");
    end
    $finish;
  end

endmodule
